>>> sv/ndr_pkg.sv
// ndr_pkg: shared types and constants for the ntfs data run decoder
// no dependencies; used by the interface users, all ndr modules and the checker

package ndr_pkg;

  // result codes
  typedef enum logic [1:0] {
    KIND_RUN   = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // decoder phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } phase_t;

  // header nibble masks
  localparam logic [7:0] HDR_LEN_MASK = 8'h0F;
  localparam logic [7:0] HDR_OFF_MASK = 8'hF0;

  // configuration register map
  localparam int CFG_IDX_W = 2;
  localparam int CFG_VAL_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_CLUSTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_SECTOR    = 2'd1;

  // cluster-to-byte scale factor
  localparam int SPC_W    = 8;
  localparam int BPS_W    = 13;
  localparam int FACTOR_W = SPC_W + BPS_W;
  localparam logic [SPC_W-1:0]    SPC_RESET    = 8'd8;
  localparam logic [BPS_W-1:0]    BPS_RESET    = 13'd512;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 21'd4096;

  typedef struct packed {
    logic [7:0] list_byte;
    logic       list_start;
  } byte_item_t;

  typedef struct packed {
    kind_t              result_kind;
    logic signed [63:0] start_cluster;
    logic [63:0]        length_clusters;
    logic [63:0]        length_bytes;
  } run_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_item_t;

  // decoded run passed from decode to scale
  typedef struct packed {
    kind_t              kind;
    logic signed [63:0] start_cluster;
    logic [63:0]        length_clusters;
  } run_rec_t;

endpackage

>>> sv/ndr_stream_if.sv
// ndr_stream_if: valid/ready channel carrying one payload item
// payload type is a parameter; used with ndr_pkg struct types

interface ndr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> sv/ndr_cfg.sv
// ndr_cfg: configuration registers and the registered cluster-to-byte factor
// depends on ndr_pkg and ndr_stream_if

module ndr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  ndr_stream_if.sink                    cfg,
  output logic [ndr_pkg::FACTOR_W-1:0]  factor
);

  logic [ndr_pkg::SPC_W-1:0] sectors_per_cluster;
  logic [ndr_pkg::BPS_W-1:0] bytes_per_sector;

  // writes always taken
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_cluster <= ndr_pkg::SPC_RESET;
      bytes_per_sector    <= ndr_pkg::BPS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        ndr_pkg::REG_SECTORS_PER_CLUSTER: begin
          sectors_per_cluster <= cfg.data.value[ndr_pkg::SPC_W-1:0];
        end
        ndr_pkg::REG_BYTES_PER_SECTOR: begin
          bytes_per_sector <= cfg.data.value[ndr_pkg::BPS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // bytes per cluster, registered product of the two registers
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= ndr_pkg::FACTOR_RESET;
    end else begin
      factor <= ndr_pkg::FACTOR_W'(sectors_per_cluster) * ndr_pkg::FACTOR_W'(bytes_per_sector);
    end
  end

endmodule

>>> sv/ndr_decode.sv
// ndr_decode: header/length/offset byte parser and running cluster adder
// depends on ndr_pkg and ndr_stream_if; feeds ndr_scale with a registered run record

module ndr_decode #(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  ndr_stream_if.sink        byte_stream,
  input  logic              rec_ready,
  output ndr_pkg::run_rec_t rec,
  output logic              rec_valid
);

  localparam int ACC_W = 8 * MAX_FIELD_BYTES;
  localparam int CNT_W = $clog2(MAX_FIELD_BYTES + 1);

  ndr_pkg::phase_t    phase, phase_next, eff_phase;
  logic [3:0]         length_size, length_size_next;
  logic [3:0]         offset_size, offset_size_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic [ACC_W-1:0]   length_accum, length_accum_next;
  logic [ACC_W-1:0]   offset_accum, offset_accum_next;
  logic [63:0]        running_cluster, running_cluster_next;

  logic               take;
  logic [7:0]         b;
  logic [ACC_W-1:0]   byte_lane;
  logic [3:0]         cnt_inc;
  logic [3:0]         len_nib, off_nib;
  logic [ACC_W-1:0]   off_src;
  logic [63:0]        off_src64;
  logic               off_sign;
  logic [63:0]        off_sext;
  logic [63:0]        run_base;
  logic [63:0]        run_sum;
  logic               emit;
  ndr_pkg::run_rec_t  emit_rec;

  assign take              = byte_stream.valid && byte_stream.ready;
  assign byte_stream.ready = !rec_valid || rec_ready;
  assign b                 = byte_stream.data.list_byte;

  // list_start restarts at a header with the cluster cleared
  assign eff_phase = byte_stream.data.list_start ? ndr_pkg::PH_HEADER : phase;
  assign run_base  = byte_stream.data.list_start ? 64'd0 : running_cluster;

  // header nibbles
  assign len_nib = 4'(b & ndr_pkg::HDR_LEN_MASK);
  assign off_nib = 4'((b & ndr_pkg::HDR_OFF_MASK) >> 4);

  // place the byte in its little-endian lane
  always_comb begin
    byte_lane = '0;
    for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
      if (byte_count == CNT_W'(i)) begin
        byte_lane[8*i +: 8] = b;
      end
    end
  end

  assign cnt_inc = 4'(byte_count) + 4'd1;

  // sign-extend the offset field from its own size
  assign off_src   = (eff_phase == ndr_pkg::PH_OFFSET) ? (offset_accum | byte_lane)
                                                         : offset_accum;
  assign off_src64 = 64'(off_src);

  always_comb begin
    off_sign = 1'b0;
    for (int i = 1; i <= MAX_FIELD_BYTES; i++) begin
      if (offset_size == 4'(i)) begin
        off_sign = off_src64[8*i-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < offset_size) begin
        off_sext[8*j +: 8] = off_src64[8*j +: 8];
      end else begin
        off_sext[8*j +: 8] = {8{off_sign}};
      end
    end
  end

  assign run_sum = run_base + off_sext;

  // next state and result
  always_comb begin
    phase_next           = phase;
    length_size_next     = length_size;
    offset_size_next     = offset_size;
    byte_count_next      = byte_count;
    length_accum_next    = length_accum;
    offset_accum_next    = offset_accum;
    running_cluster_next = running_cluster;
    emit                 = 1'b0;
    emit_rec.kind            = ndr_pkg::KIND_RUN;
    emit_rec.start_cluster   = '0;
    emit_rec.length_clusters = '0;
    if (take) begin
      running_cluster_next = run_base;
      unique case (eff_phase)
        ndr_pkg::PH_LENGTH: begin
          length_accum_next = length_accum | byte_lane;
          byte_count_next   = CNT_W'(cnt_inc);
          if (cnt_inc >= length_size) begin
            byte_count_next = '0;
            if (offset_size == 4'd0) begin
              running_cluster_next     = run_sum;
              phase_next               = ndr_pkg::PH_HEADER;
              emit                     = 1'b1;
              emit_rec.kind            = ndr_pkg::KIND_RUN;
              emit_rec.start_cluster   = run_sum;
              emit_rec.length_clusters = 64'(length_accum | byte_lane);
            end else begin
              phase_next = ndr_pkg::PH_OFFSET;
            end
          end
        end
        ndr_pkg::PH_OFFSET: begin
          offset_accum_next = offset_accum | byte_lane;
          byte_count_next   = CNT_W'(cnt_inc);
          if (cnt_inc >= offset_size) begin
            byte_count_next          = '0;
            running_cluster_next     = run_sum;
            phase_next               = ndr_pkg::PH_HEADER;
            emit                     = 1'b1;
            emit_rec.kind            = ndr_pkg::KIND_RUN;
            emit_rec.start_cluster   = run_sum;
            emit_rec.length_clusters = 64'(length_accum);
          end
        end
        default: begin
          // header byte
          phase_next        = ndr_pkg::PH_HEADER;
          byte_count_next   = '0;
          length_accum_next = '0;
          offset_accum_next = '0;
          if (b == 8'd0) begin
            length_size_next = 4'd0;
            offset_size_next = 4'd0;
            emit             = 1'b1;
            emit_rec.kind    = ndr_pkg::KIND_END;
          end else if (len_nib > 4'(MAX_FIELD_BYTES) || off_nib > 4'(MAX_FIELD_BYTES)) begin
            length_size_next = 4'd0;
            offset_size_next = 4'd0;
            emit             = 1'b1;
            emit_rec.kind    = ndr_pkg::KIND_ERROR;
          end else begin
            length_size_next = len_nib;
            offset_size_next = off_nib;
            phase_next       = (len_nib != 4'd0) ? ndr_pkg::PH_LENGTH : ndr_pkg::PH_OFFSET;
          end
        end
      endcase
    end
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ndr_pkg::PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  // field sizes, accumulators and running cluster
  always_ff @(posedge clk) begin
    if (rst) begin
      length_size     <= '0;
      offset_size     <= '0;
      byte_count      <= '0;
      length_accum    <= '0;
      offset_accum    <= '0;
      running_cluster <= '0;
    end else begin
      length_size     <= length_size_next;
      offset_size     <= offset_size_next;
      byte_count      <= byte_count_next;
      length_accum    <= length_accum_next;
      offset_accum    <= offset_accum_next;
      running_cluster <= running_cluster_next;
    end
  end

  // run record register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      rec_valid <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.ready) begin
      rec <= emit_rec;
    end
  end

endmodule

>>> sv/ndr_scale.sv
// ndr_scale: two-stage length-to-bytes multiply with saturation and output register
// depends on ndr_pkg and ndr_stream_if; takes run records from ndr_decode

module ndr_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  ndr_pkg::run_rec_t            rec,
  input  logic                         rec_valid,
  output logic                         rec_ready,
  input  logic [ndr_pkg::FACTOR_W-1:0] factor,
  ndr_stream_if.source                 run_stream
);

  localparam int PROD_W = 32 + ndr_pkg::FACTOR_W;
  localparam int FULL_W = 64 + ndr_pkg::FACTOR_W;

  logic              prod_valid;
  ndr_pkg::run_rec_t prod_rec;
  logic [PROD_W-1:0] prod_lo, prod_hi;
  logic              prod_ready, out_ready;
  logic [FULL_W-1:0] full;
  logic              sat;

  assign out_ready  = !run_stream.valid || run_stream.ready;
  assign prod_ready = !prod_valid || out_ready;
  assign rec_ready  = prod_ready;

  // partial products, low and high halves of the length
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready) begin
      prod_rec <= rec;
      prod_lo  <= PROD_W'(rec.length_clusters[31:0]) * PROD_W'(factor);
      prod_hi  <= PROD_W'(rec.length_clusters[63:32]) * PROD_W'(factor);
    end
  end

  // combine and saturate
  assign full = {prod_hi, 32'd0} + FULL_W'(prod_lo);
  assign sat  = |full[FULL_W-1:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      run_stream.valid <= 1'b0;
    end else if (out_ready) begin
      run_stream.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      run_stream.data.result_kind     <= prod_rec.kind;
      run_stream.data.start_cluster   <= prod_rec.start_cluster;
      run_stream.data.length_clusters <= prod_rec.length_clusters;
      run_stream.data.length_bytes    <= sat ? '1 : full[63:0];
    end
  end

endmodule

>>> sv/ntfs_data_run_decoder_top.sv
// ntfs_data_run_decoder_top: one run list byte accepted per cycle unless a stalled output backs up
// the result of a closing byte (or a zero/bad header) passes run record, product and output registers
// stages: parse and cluster add, split 32x21 multiplies, combine and saturate
// a configuration write is taken into its register, then into the registered byte scale factor
// synchronous reset: expects a header, running cluster zero, registers 8 and 512

module ntfs_data_run_decoder_top #(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst,
  ndr_stream_if.sink   cfg,
  ndr_stream_if.sink   byte_stream,
  ndr_stream_if.source run_stream
);

  logic [ndr_pkg::FACTOR_W-1:0] factor;
  ndr_pkg::run_rec_t            rec;
  logic                         rec_valid;
  logic                         rec_ready;

  // configuration registers
  ndr_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .factor (factor)
  );

  // byte parser
  ndr_decode #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .rec_ready   (rec_ready),
    .rec         (rec),
    .rec_valid   (rec_valid)
  );

  // byte length and output register
  ndr_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .rec        (rec),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .factor     (factor),
    .run_stream (run_stream)
  );

endmodule

>>> sv/ndr_check.sv
// ndr_check: port-level assertions for the run decoder output channel
// depends on ndr_pkg; bound to ntfs_data_run_decoder_top below

module ndr_check (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input ndr_pkg::kind_t     result_kind,
  input logic signed [63:0] start_cluster,
  input logic [63:0]        length_clusters,
  input logic [63:0]        length_bytes
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(start_cluster) && $stable(length_clusters) && $stable(length_bytes))
    else $error("stalled result changed");

  // end and error results carry zero fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != ndr_pkg::KIND_RUN |->
      start_cluster == '0 && length_clusters == '0 && length_bytes == '0)
    else $error("end or error result with nonzero fields");

  // empty run has no bytes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == ndr_pkg::KIND_RUN && length_clusters == '0 |->
      length_bytes == '0)
    else $error("zero cluster run with nonzero byte length");

endmodule

bind ntfs_data_run_decoder_top ndr_check u_ndr_check (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (run_stream.valid),
  .out_ready       (run_stream.ready),
  .result_kind     (run_stream.data.result_kind),
  .start_cluster   (run_stream.data.start_cluster),
  .length_clusters (run_stream.data.length_clusters),
  .length_bytes    (run_stream.data.length_bytes)
);

>>> bench/ntfs_data_run_decoder_top_test.sv
// ntfs_data_run_decoder_top_test: self-checking bench for the ntfs data run decoder
// depends on ndr_pkg, ndr_stream_if and ntfs_data_run_decoder_top from the rtl
// predicts each run, end and error item and checks them in order under random idling
`timescale 1ns / 1ps

module ntfs_data_run_decoder_top_test;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_BYTES     = 8;
  localparam int PRINT_LIMIT   = 100;

  logic clk;
  logic rst;

  ndr_stream_if #(.payload_t(ndr_pkg::cfg_item_t))  cfg_ch ();
  ndr_stream_if #(.payload_t(ndr_pkg::byte_item_t)) byte_ch ();
  ndr_stream_if #(.payload_t(ndr_pkg::run_item_t))  run_ch ();

  ntfs_data_run_decoder_top #(.MAX_FIELD_BYTES(MAX_BYTES)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .byte_stream (byte_ch),
    .run_stream  (run_ch)
  );

  // decoder model state and registers
  logic [7:0]       spc_reg;
  logic [12:0]      bps_reg;
  ndr_pkg::phase_t  dec_phase;
  logic [3:0]       len_size;
  logic [3:0]       off_size;
  logic [3:0]       field_count;
  logic [63:0]      len_acc;
  logic [63:0]      off_acc;
  logic [63:0]      cluster_sum;

  ndr_pkg::run_item_t expected_runs[$];

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    run_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  function void reset_decoder_model();
    spc_reg     = ndr_pkg::SPC_RESET;
    bps_reg     = ndr_pkg::BPS_RESET;
    dec_phase   = ndr_pkg::PH_HEADER;
    len_size    = '0;
    off_size    = '0;
    field_count = '0;
    len_acc     = '0;
    off_acc     = '0;
    cluster_sum = '0;
  endfunction

  function automatic logic [63:0] sign_extend_offset(logic [63:0] v, logic [3:0] n);
    logic [63:0] mask;
    if (n == 0 || n >= 8) return v;
    mask = (64'd1 << (n * 8)) - 64'd1;
    v = v & mask;
    if (v[n * 8 - 1]) v = v | ~mask;
    return v;
  endfunction

  // clusters times sectors times bytes, saturated at all ones
  function automatic logic [63:0] run_bytes(logic [63:0] clusters);
    logic [127:0] prod;
    prod = 128'(clusters) * 128'(spc_reg) * 128'(bps_reg);
    if (prod[127:64] != '0) return '1;
    return prod[63:0];
  endfunction

  function void close_run();
    ndr_pkg::run_item_t r;
    cluster_sum       = cluster_sum + sign_extend_offset(off_acc, off_size);
    r.result_kind     = ndr_pkg::KIND_RUN;
    r.start_cluster   = cluster_sum;
    r.length_clusters = len_acc;
    r.length_bytes    = run_bytes(len_acc);
    expected_runs.insert(expected_runs.size(), r);
    dec_phase   = ndr_pkg::PH_HEADER;
    field_count = '0;
  endfunction

  function void push_flag(ndr_pkg::kind_t k);
    ndr_pkg::run_item_t r;
    r = '0;
    r.result_kind = k;
    expected_runs.insert(expected_runs.size(), r);
  endfunction

  // one list byte through the model
  function void decode_list_byte(logic [7:0] b, logic s);
    if (s) begin
      cluster_sum = '0;
      dec_phase   = ndr_pkg::PH_HEADER;
    end
    case (dec_phase)
      ndr_pkg::PH_LENGTH: begin
        len_acc     = len_acc | (64'(b) << (field_count[2:0] * 8));
        field_count = field_count + 4'd1;
        if (field_count >= len_size) begin
          field_count = '0;
          if (off_size == 0) close_run();
          else dec_phase = ndr_pkg::PH_OFFSET;
        end
      end
      ndr_pkg::PH_OFFSET: begin
        off_acc     = off_acc | (64'(b) << (field_count[2:0] * 8));
        field_count = field_count + 4'd1;
        if (field_count >= off_size) close_run();
      end
      default: begin
        dec_phase   = ndr_pkg::PH_HEADER;
        field_count = '0;
        len_acc     = '0;
        off_acc     = '0;
        if (b == 8'h00) begin
          len_size = '0;
          off_size = '0;
          push_flag(ndr_pkg::KIND_END);
        end else begin
          len_size = 4'(b & ndr_pkg::HDR_LEN_MASK);
          off_size = 4'((b & ndr_pkg::HDR_OFF_MASK) >> 4);
          if (len_size > MAX_BYTES || off_size > MAX_BYTES) begin
            len_size = '0;
            off_size = '0;
            push_flag(ndr_pkg::KIND_ERROR);
          end else begin
            dec_phase = (len_size != 0) ? ndr_pkg::PH_LENGTH : ndr_pkg::PH_OFFSET;
          end
        end
      end
    endcase
  endfunction

  task report_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    if (errors < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
    errors++;
  endtask

  task check_decoded_run(input ndr_pkg::run_item_t got);
    ndr_pkg::run_item_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch("item with none pending, kind", '0, 64'(got.result_kind));
    end else begin
      want = expected_runs.pop_front();
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      if (got.start_cluster !== want.start_cluster)
        report_mismatch("start_cluster", want.start_cluster, got.start_cluster);
      if (got.length_clusters !== want.length_clusters)
        report_mismatch("length_clusters", want.length_clusters, got.length_clusters);
      if (got.length_bytes !== want.length_bytes)
        report_mismatch("length_bytes", want.length_bytes, got.length_bytes);
    end
  endtask

  // watch all three channels, predict on bytes, check on results
  always @(posedge clk) begin
    if (rst) begin
      reset_decoder_model();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          ndr_pkg::REG_SECTORS_PER_CLUSTER: spc_reg = cfg_ch.data.value[7:0];
          ndr_pkg::REG_BYTES_PER_SECTOR:    bps_reg = cfg_ch.data.value;
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready)
        decode_list_byte(byte_ch.data.list_byte, byte_ch.data.list_start);
      if (run_ch.valid && run_ch.ready)
        check_decoded_run(run_ch.data);
    end
  end

  // one list byte, with random gaps ahead of it
  task send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid           <= 1'b1;
    byte_ch.data.list_byte  <= b;
    byte_ch.data.list_start <= s;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  // hold off bytes until every pending item is back, then let the pipe empty
  task wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [ndr_pkg::CFG_IDX_W-1:0] idx,
                 input logic [ndr_pkg::CFG_VAL_W-1:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.value <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task apply_config(input logic [ndr_pkg::CFG_VAL_W-1:0] spc,
                    input logic [ndr_pkg::CFG_VAL_W-1:0] bps);
    wait_drained();
    write_reg(ndr_pkg::REG_SECTORS_PER_CLUSTER, spc);
    write_reg(ndr_pkg::REG_BYTES_PER_SECTOR, bps);
  endtask

  task set_idle(input int send_pct, input int stall_pct);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // field bytes leaning on sign and extreme values
  function automatic logic [7:0] rand_list_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed run lists, some noise and truncated runs
  task run_lists(input int n);
    int target;
    int nruns;
    int lsz;
    int osz;
    int nb;
    logic restart;
    target  = bytes_sent + n;
    restart = 1'b1;
    while (bytes_sent < target) begin
      if ($urandom_range(99) < 8) begin
        send_byte(8'($urandom), ($urandom_range(3) == 0));
        restart = 1'($urandom_range(1));
      end else begin
        nruns = $urandom_range(1, 5);
        for (int r = 0; r < nruns; r++) begin
          lsz = $urandom_range(0, MAX_BYTES);
          osz = $urandom_range(0, MAX_BYTES);
          if (lsz == 0 && osz == 0) lsz = 1;
          send_byte({4'(osz), 4'(lsz)}, (r == 0) && (restart || ($urandom_range(1) == 1)));
          restart = 1'b0;
          nb = lsz + osz;
          // cut the run short and mark the next list to restart over it
          if ($urandom_range(99) < 4) begin
            nb = $urandom_range(0, nb - 1);
            restart = 1'b1;
          end
          for (int i = 0; i < nb; i++) send_byte(rand_list_byte(), 1'b0);
          if (restart) break;
        end
        if (!restart && $urandom_range(99) < 85) send_byte(8'h00, 1'b0);
      end
    end
  endtask

  // every kind, sign of offsets, empty fields, restart, saturation
  task test_directed();
    set_idle(0, 0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h11, 1'b1); send_byte(8'h40, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h11, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h80, 1'b0);
    // offset only, zero length
    send_byte(8'h10, 1'b0); send_byte(8'h02, 1'b0);
    // oversized nibbles
    send_byte(8'h09, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'hFF, 1'b0);
    // new list in the middle of a run
    send_byte(8'h22, 1'b0); send_byte(8'h34, 1'b0); send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b1);
    // sparse run with full length, saturating the byte count
    send_byte(8'h08, 1'b0);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
  endtask

  task test_no_idle();
    apply_config(13'd1, 13'd256);
    set_idle(0, 0);
    run_lists(300);
  endtask

  task test_sender_idle();
    apply_config(13'd128, 13'd4096);
    set_idle(46, 0);
    run_lists(400);
  endtask

  task test_receiver_stall();
    // upper bits of the sectors write are dropped
    apply_config(13'h1FFF, 13'd8191);
    set_idle(0, 46);
    run_lists(400);
  endtask

  task test_both_idle();
    apply_config(13'd16, 13'd1024);
    set_idle(20, 20);
    run_lists(400);
  endtask

  task test_odd_registers();
    set_idle(20, 20);
    apply_config(13'd0, 13'd512);
    run_lists(150);
    apply_config(13'd8, 13'd0);
    run_lists(100);
    apply_config(13'h1F01, 13'd1);
    run_lists(100);
    apply_config(13'd8, 13'd512);
    run_lists(100);
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    byte_ch.valid       = 1'b0;
    byte_ch.data        = '0;
    run_ch.ready        = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_odd_registers();
    wait_drained();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
sv/ndr_pkg.sv
sv/ndr_stream_if.sv
sv/ndr_cfg.sv
sv/ndr_decode.sv
sv/ndr_scale.sv
sv/ntfs_data_run_decoder_top.sv
sv/ndr_check.sv
bench/ntfs_data_run_decoder_top_test.sv
